// File: sv/partition_round_robin_dispatcher_top_defines.svh
// Assertion macros shared by the dispatcher checker.
`ifndef PARTITION_ROUND_ROBIN_DISPATCHER_TOP_DEFINES_SVH
`define PARTITION_ROUND_ROBIN_DISPATCHER_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define PRRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PRRD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/prrd_pkg.sv
// Shared types, constants and command/status bundles for the dispatcher.
package prrd_pkg;

  // Default sizing
  localparam int PARTITIONS_DEF    = 16;
  localparam int MAX_CONSUMERS_DEF = 8;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int PART_W   = 4;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SUB   = 2'd0,
    OP_UNSUB = 2'd1,
    OP_DLV   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Read index source for the list memory
  typedef enum logic [1:0] {
    RD_IDX,
    RD_NEXT,
    RD_REM
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_US_CHK,
    S_US_RD,
    S_US_CMP,
    S_SH_RD,
    S_SH_WR,
    S_US_DEC,
    S_US_NEXT,
    S_DLV_MOD,
    S_DLV_TAKE,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    sub_write;
    logic    sh_write;
    rd_sel_t rd_sel;
    logic    idx_inc;
    logic    idx_clr;
    logic    part_inc;
    logic    len_dec;
    logic    rem_start;
    logic    dlv_take;
    logic    set_res;
    status_t res_status;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic p_ok;
    logic len_zero;
    logic len_full;
    logic hit;
    logic idx_more;
    logic idx_more2;
    logic part_last;
    logic rem_done;
  } sts_t;

endpackage

// File: sv/prrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/prrd_rem.sv
// Bit-serial remainder unit: counter modulo list length, one bit per cycle.
module prrd_rem #(
  parameter int LW = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prrd_pkg::CNT_W-1:0] dividend,
  input  logic [LW-1:0]              divisor,
  output logic                       busy,
  output logic [LW-1:0]              rem
);
  import prrd_pkg::*;

  localparam int SW = $clog2(CNT_W + 1);

  logic          busy_r;
  logic [SW-1:0] step_r;
  logic [CNT_W-1:0] dvd_r;
  logic [LW-1:0] div_r;
  logic [LW-1:0] rem_r;
  logic [LW:0]   trial;
  logic          ge;
  logic [LW-1:0] rem_nxt;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial   = {rem_r, dvd_r[CNT_W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? LW'(trial - {1'b0, div_r}) : trial[LW-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= SW'(CNT_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == SW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Operand and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[CNT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign rem  = rem_r;

endmodule

// File: sv/prrd_datapath.sv
// Datapath: list memory, lengths, delivery counters, remainder unit, result registers.
module prrd_datapath #(
  parameter int PARTITIONS    = prrd_pkg::PARTITIONS_DEF,
  parameter int MAX_CONSUMERS = prrd_pkg::MAX_CONSUMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prrd_pkg::cmd_t                cmd,
  output prrd_pkg::sts_t                sts,
  input  logic [prrd_pkg::OP_W-1:0]     in_op,
  input  logic [prrd_pkg::PART_W-1:0]   in_partition,
  input  logic [prrd_pkg::ID_W-1:0]     in_consumer,
  output logic [prrd_pkg::STATUS_W-1:0] out_status,
  output logic [prrd_pkg::ID_W-1:0]     out_target
);
  import prrd_pkg::*;

  localparam int PW    = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int IW    = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
  localparam int LW    = $clog2(MAX_CONSUMERS + 1);
  localparam int DEPTH = PARTITIONS * MAX_CONSUMERS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = PW + LW;

  op_t              op_r;
  logic             p_ok_r;
  logic [ID_W-1:0]  id_r;
  logic [PW-1:0]    part_r;
  logic [IW-1:0]    idx_r;
  logic [LW-1:0]    lens_r [PARTITIONS];
  logic [CNT_W-1:0] cnt_r  [PARTITIONS];
  status_t          res_status_r;
  logic [ID_W-1:0]  res_target_r;
  status_t          out_status_r;
  logic [ID_W-1:0]  out_target_r;

  logic             part_in_range;
  logic [LW-1:0]    len_cur;
  logic [CNT_W-1:0] cnt_cur;
  logic [AW-1:0]    base;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    wr_idx;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [ID_W-1:0]  wdata;
  logic             we;
  logic [ID_W-1:0]  rdata;
  logic             rem_busy;
  logic [LW-1:0]    rem;
  logic             in_p_ok;

  // Current partition's length and counter, zero outside the table
  always_comb begin
    part_in_range = ({1'b0, part_r} < (PW+1)'(PARTITIONS));
    len_cur       = part_in_range ? lens_r[part_r] : '0;
    cnt_cur       = part_in_range ? cnt_r[part_r] : '0;
    base          = AW'(BW'(part_r) * BW'(MAX_CONSUMERS));
  end

  // Memory address and write data selection
  always_comb begin
    unique case (cmd.rd_sel)
      RD_IDX:  rd_idx = idx_r;
      RD_NEXT: rd_idx = idx_r + 1'b1;
      RD_REM:  rd_idx = IW'(rem);
      default: rd_idx = idx_r;
    endcase
    wr_idx = cmd.sub_write ? IW'(len_cur) : idx_r;
    raddr  = base + AW'(rd_idx);
    waddr  = base + AW'(wr_idx);
    wdata  = cmd.sub_write ? id_r : rdata;
    we     = cmd.sub_write | cmd.sh_write;
  end

  prrd_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  prrd_rem #(
    .LW (LW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (cnt_cur),
    .divisor  (len_cur),
    .busy     (rem_busy),
    .rem      (rem)
  );

  assign in_p_ok = (9'(in_partition) < 9'(PARTITIONS));

  // Capture the transfer and walk the list indexes
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op_t'(in_op);
      id_r   <= in_consumer;
      p_ok_r <= in_p_ok;
      part_r <= (op_t'(in_op) == OP_UNSUB) ? '0 : PW'(in_partition);
      idx_r  <= '0;
    end else begin
      if (cmd.part_inc) begin
        part_r <= part_r + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Lengths and delivery counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PARTITIONS; i++) begin
        lens_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cmd.sub_write) begin
        lens_r[part_r] <= len_cur + 1'b1;
      end else if (cmd.len_dec) begin
        lens_r[part_r] <= len_cur - 1'b1;
      end
      if (cmd.dlv_take) begin
        cnt_r[part_r] <= cnt_cur + 1'b1;
      end
    end
  end

  // Result and output registers
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_target_r <= cmd.dlv_take ? rdata : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_target_r <= res_target_r;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.op        = op_r;
    sts.p_ok      = p_ok_r;
    sts.len_zero  = (len_cur == '0);
    sts.len_full  = (len_cur >= LW'(MAX_CONSUMERS));
    sts.hit       = (rdata == id_r);
    sts.idx_more  = ((LW+1)'(idx_r) + (LW+1)'(1)) < (LW+1)'(len_cur);
    sts.idx_more2 = ((LW+1)'(idx_r) + (LW+1)'(2)) < (LW+1)'(len_cur);
    sts.part_last = ((PW+1)'(part_r) == (PW+1)'(PARTITIONS - 1));
    sts.rem_done  = !rem_busy;
  end

  assign out_status = out_status_r;
  assign out_target = out_target_r;

endmodule

// File: sv/prrd_ctrl.sv
// Controller: sequences subscribe, unsubscribe walk and delivery, owns the handshakes.
module prrd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  prrd_pkg::sts_t sts,
  output prrd_pkg::cmd_t cmd
);
  import prrd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_SUB:   state_nxt = S_DONE;
          OP_UNSUB: state_nxt = S_US_CHK;
          OP_DLV: begin
            if (!sts.p_ok || sts.len_zero) state_nxt = S_DONE;
            else state_nxt = S_DLV_MOD;
          end
          OP_NOP:   state_nxt = S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_US_CHK: begin
        state_nxt = sts.len_zero ? S_US_NEXT : S_US_CMP;
      end
      S_US_RD:  state_nxt = S_US_CMP;
      S_US_CMP: begin
        priority if (sts.hit && sts.idx_more) state_nxt = S_SH_RD;
        else if (sts.hit) state_nxt = S_US_DEC;
        else if (sts.idx_more) state_nxt = S_US_RD;
        else state_nxt = S_US_NEXT;
      end
      S_SH_RD:  state_nxt = S_SH_WR;
      S_SH_WR: begin
        state_nxt = sts.idx_more2 ? S_SH_RD : S_US_DEC;
      end
      S_US_DEC: state_nxt = S_US_NEXT;
      S_US_NEXT: begin
        state_nxt = sts.part_last ? S_DONE : S_US_CHK;
      end
      S_DLV_MOD: begin
        if (sts.rem_done) state_nxt = S_DLV_TAKE;
      end
      S_DLV_TAKE: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RD_IDX;
    cmd.res_status = ST_DONE;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        unique case (sts.op)
          OP_SUB: begin
            if (!sts.p_ok || sts.len_full) cmd.res_status = ST_FULL;
            else cmd.sub_write = 1'b1;
          end
          OP_UNSUB: cmd.set_res = 1'b0;
          OP_DLV: begin
            if (!sts.p_ok || sts.len_zero) begin
              cmd.res_status = ST_NONE;
            end else begin
              cmd.set_res   = 1'b0;
              cmd.rem_start = 1'b1;
            end
          end
          OP_NOP:  cmd.res_status = ST_DONE;
          default: cmd.res_status = ST_DONE;
        endcase
      end
      S_US_CHK: cmd.rd_sel = RD_IDX;
      S_US_RD:  cmd.rd_sel = RD_IDX;
      S_US_CMP: begin
        if (!sts.hit && sts.idx_more) cmd.idx_inc = 1'b1;
      end
      S_SH_RD:  cmd.rd_sel = RD_NEXT;
      S_SH_WR: begin
        cmd.sh_write = 1'b1;
        cmd.idx_inc  = 1'b1;
        cmd.rd_sel   = RD_IDX;
      end
      S_US_DEC: cmd.len_dec = 1'b1;
      S_US_NEXT: begin
        cmd.idx_clr = 1'b1;
        if (sts.part_last) begin
          cmd.set_res = 1'b1;
        end else begin
          cmd.part_inc = 1'b1;
        end
      end
      S_DLV_MOD: cmd.rd_sel = RD_REM;
      S_DLV_TAKE: begin
        cmd.set_res  = 1'b1;
        cmd.dlv_take = 1'b1;
      end
      S_DONE: cmd.out_load = slot_free;
      default: cmd.rd_sel = RD_IDX;
    endcase
  end

  // Output valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/partition_round_robin_dispatcher_top.sv
// Partition round-robin dispatcher: command in, one status/target result out.
//
// Input channel (in_valid/in_ready): op, partition, consumer. One result per
// transfer on the output channel (out_valid/out_ready): status and target.
// Items are handled one at a time; in_ready is high only while the sequencer
// is idle. The result sits in an output register, so the next command is
// taken while a finished result still waits for the receiver.
// Subscribe, unused op and deliver on an empty or unknown partition go from
// decode straight to the result. Any other deliver waits for the 32-step
// bit-serial remainder of the counter by the list length. Unsubscribe walks
// the list of every partition through the list memory: it compares entries,
// shifts the later entries down over the first match and shortens that list.
// in_ready returns in the cycle out_valid rises.
// A stalled receiver holds the result; a new result waits in the sequencer
// until the output register frees.
// Reset (rst_n low, synchronous) empties all lists and zeroes every delivery
// counter; list memory contents are not cleared and need no clearing pass.
module partition_round_robin_dispatcher_top #(
  parameter int PARTITIONS    = prrd_pkg::PARTITIONS_DEF,
  parameter int MAX_CONSUMERS = prrd_pkg::MAX_CONSUMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [prrd_pkg::OP_W-1:0]     in_op,
  input  logic [prrd_pkg::PART_W-1:0]   in_partition,
  input  logic [prrd_pkg::ID_W-1:0]     in_consumer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [prrd_pkg::STATUS_W-1:0] out_status,
  output logic [prrd_pkg::ID_W-1:0]     out_target
);
  import prrd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prrd_datapath #(
    .PARTITIONS    (PARTITIONS),
    .MAX_CONSUMERS (MAX_CONSUMERS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_partition (in_partition),
    .in_consumer  (in_consumer),
    .out_status   (out_status),
    .out_target   (out_target)
  );

endmodule

// File: sv/prrd_checker.sv
// Port-level checker for the dispatcher, bound to the top level.
`include "partition_round_robin_dispatcher_top_defines.svh"

module prrd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [prrd_pkg::STATUS_W-1:0] out_status,
  input logic [prrd_pkg::ID_W-1:0]     out_target
);
  import prrd_pkg::*;

  // Reset leaves no result pending and the sequencer idle
  `PRRD_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && in_ready, "reset did not idle")

  // A transfer on the input always starts a multi-cycle sequence
  `PRRD_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "ready after transfer")

  // Only defined status codes leave the block
  `PRRD_ASSERT(a_status_code, out_valid |-> (out_status == ST_DONE || out_status == ST_NONE || out_status == ST_FULL), "bad status code")

  // Failures carry no target
  `PRRD_ASSERT(a_fail_target, out_valid && out_status != ST_DONE |-> out_target == '0, "target on failure")

  // A stalled result holds
  `PRRD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_target), "result changed while stalled")

endmodule

bind partition_round_robin_dispatcher_top prrd_checker u_prrd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_status (out_status),
  .out_target (out_target)
);

// File: test/tb_top.sv
// Self-checking testbench for the partition round-robin dispatcher.
`timescale 1ns / 1ps

module tb_top;
  import prrd_pkg::*;

  localparam int NPART = PARTITIONS_DEF;
  localparam int NCONS = MAX_CONSUMERS_DEF;
  localparam int RANDOM_CMDS = 1625;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    op_t              op;
    logic [PART_W-1:0] part;
    logic [ID_W-1:0]   id;
  } cmd_item_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] target;
  } dispatch_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = '0;
  logic [PART_W-1:0]   in_partition = '0;
  logic [ID_W-1:0]     in_consumer = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [ID_W-1:0]     out_target;

  // Command stream and expected results
  cmd_item_t        cmd_q[$];
  dispatch_result_t result_q[$];
  cmd_item_t        cur_cmd;
  int               cmd_total = 0;
  int               cmds_issued = 0;
  int               cmds_accepted = 0;
  int               fail_cnt = 0;
  logic [1:0]       idle_phase = 2'd0;
  int               hold_left = 0;
  bit               hold_done = 1'b0;

  // Shadow of the dispatcher state
  logic [ID_W-1:0]  sub_lists[NPART][NCONS];
  int               sub_len[NPART];
  logic [CNT_W-1:0] dlv_count[NPART];

  logic [ID_W-1:0]  id_pool[16];

  partition_round_robin_dispatcher_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_partition (in_partition),
    .in_consumer  (in_consumer),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_target   (out_target)
  );

  always #10 clk = ~clk;

  // Idle percentage per side: sender light/receiver heavy, then swapped, then none
  function automatic int gap_percent(bit is_sender, logic [1:0] ph);
    case (ph)
      2'd0: return is_sender ? 25 : 75;
      2'd1: return is_sender ? 75 : 25;
      default: return 0;
    endcase
  endfunction

  // Apply one command to the shadow state and return the result it should produce
  function automatic dispatch_result_t predict_dispatch(cmd_item_t c);
    dispatch_result_t r;
    int hit;
    int slot;
    r.status = ST_DONE;
    r.target = '0;
    case (c.op)
      OP_SUB: begin
        if (sub_len[c.part] >= NCONS) begin
          r.status = ST_FULL;
        end else begin
          sub_lists[c.part][sub_len[c.part]] = c.id;
          sub_len[c.part]++;
        end
      end
      OP_UNSUB: begin
        // drop the first match in every list, close the gap
        for (int p = 0; p < NPART; p++) begin
          hit = -1;
          for (int i = 0; i < sub_len[p]; i++) begin
            if (hit < 0 && sub_lists[p][i] == c.id) hit = i;
          end
          if (hit >= 0) begin
            for (int k = hit; k + 1 < sub_len[p]; k++) sub_lists[p][k] = sub_lists[p][k + 1];
            sub_len[p]--;
          end
        end
      end
      OP_DLV: begin
        if (sub_len[c.part] == 0) begin
          r.status = ST_NONE;
        end else begin
          slot = int'(dlv_count[c.part] % CNT_W'(sub_len[c.part]));
          r.target = sub_lists[c.part][slot];
          dlv_count[c.part] = dlv_count[c.part] + 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_cmd(op_t op, int part, logic [ID_W-1:0] id);
    cmd_item_t c;
    c.op = op;
    c.part = PART_W'(part);
    c.id = id;
    cmd_q = {cmd_q, c};
  endfunction

  // Mostly pool ids on a few hot partitions so lists fill, repeat and drain
  function automatic void push_random_cmd();
    int sel;
    int part;
    logic [ID_W-1:0] id;
    sel = $urandom_range(99);
    part = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(NPART - 1);
    id = ($urandom_range(99) < 80) ? id_pool[$urandom_range(15)] : ID_W'($urandom);
    if (sel < 42) push_cmd(OP_SUB, part, id);
    else if (sel < 82) push_cmd(OP_DLV, part, id);
    else if (sel < 94) push_cmd(OP_UNSUB, part, id);
    else push_cmd(OP_NOP, part, id);
  endfunction

  // Driver: hold each command until its transfer, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        result_q = {result_q, predict_dispatch(cur_cmd)};
        cmds_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= gap_percent(1'b1, idle_phase)) begin
          cur_cmd = cmd_q.pop_front();
          cmds_issued++;
          in_valid <= 1'b1;
          in_op <= cur_cmd.op;
          in_partition <= cur_cmd.part;
          in_consumer <= cur_cmd.id;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (cmds_issued * 3 >= cmd_total * 2) idle_phase <= 2'd2;
      else if (cmds_issued * 3 >= cmd_total) idle_phase <= 2'd1;
      else idle_phase <= 2'd0;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && idle_phase == 2'd2) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= gap_percent(1'b0, idle_phase));
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    dispatch_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d target %h", out_status, out_target);
        fail_cnt++;
      end else begin
        exp_res = result_q.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_res.status, out_status);
          fail_cnt++;
        end
        if (out_target !== exp_res.target) begin
          $error("target mismatch: expected %h, got %h", exp_res.target, out_target);
          fail_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int p = 0; p < NPART; p++) begin
      sub_len[p] = 0;
      dlv_count[p] = '0;
    end
    for (int i = 0; i < 16; i++) id_pool[i] = ID_W'($urandom);

    // Directed: empty deliver, id extremes, round-robin order, full list
    push_cmd(OP_DLV, 0, 16'h0000);
    push_cmd(OP_SUB, 15, 16'hFFFF);
    push_cmd(OP_SUB, 15, 16'h0000);
    push_cmd(OP_DLV, 15, 16'h0000);
    push_cmd(OP_DLV, 15, 16'hFFFF);
    push_cmd(OP_DLV, 15, 16'h5A5A);
    push_cmd(OP_SUB, 0, 16'hFFFF);
    push_cmd(OP_SUB, 0, 16'h0001);
    push_cmd(OP_SUB, 0, 16'h0002);
    push_cmd(OP_SUB, 0, 16'h0003);
    push_cmd(OP_SUB, 0, 16'h0001);
    push_cmd(OP_SUB, 0, 16'h0004);
    push_cmd(OP_SUB, 0, 16'h0005);
    push_cmd(OP_SUB, 0, 16'h0006);
    push_cmd(OP_SUB, 0, 16'h0007);
    push_cmd(OP_DLV, 0, 16'h0000);
    push_cmd(OP_DLV, 0, 16'h0000);
    // Unsubscribe ignores the partition field and removes only the first duplicate
    push_cmd(OP_UNSUB, 9, 16'h0001);
    push_cmd(OP_UNSUB, 3, 16'hFFFF);
    push_cmd(OP_UNSUB, 15, 16'h1234);
    push_cmd(OP_NOP, 5, 16'hABCD);
    push_cmd(OP_DLV, 15, 16'h0000);
    push_cmd(OP_DLV, 0, 16'h0000);
    push_cmd(OP_DLV, 10, 16'hFFFF);

    for (int n = 0; n < RANDOM_CMDS; n++) push_random_cmd();
    cmd_total = cmd_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all commands accepted, all results seen, then a short tail
    while (cmds_accepted < cmd_total) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/prrd_pkg.sv
sv/prrd_ram.sv
sv/prrd_rem.sv
sv/prrd_datapath.sv
sv/prrd_ctrl.sv
sv/partition_round_robin_dispatcher_top.sv
sv/prrd_checker.sv
test/tb_top.sv
